>>> rtl/core/lez_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lez_pkg
// Shared types and a saturating add/subtract helper for the lorenz euler step block.
// ----------------------------------------------------------------------------
package lez_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STEP_W = 31;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // register indexes of the configuration port
  localparam logic [1:0] REG_SIGMA = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_RHO   = 2'd2;
  localparam logic [1:0] REG_STEP  = 2'd3;

  typedef struct packed {
    logic                     ovf;
    logic signed [DATA_W-1:0] val;
  } sat_res_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sigma_gain;
    logic signed [DATA_W-1:0] beta_gain;
    logic signed [DATA_W-1:0] rho_gain;
    logic        [STEP_W-1:0] time_step;
  } cfg_t;

  function automatic sat_res_t sat_addsub(input logic signed [DATA_W-1:0] a,
                                          input logic signed [DATA_W-1:0] b,
                                          input logic                     sub);
    logic signed [DATA_W:0] s;
    sat_res_t               r;
    if (sub) begin
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    end else begin
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    end
    r.ovf = s[DATA_W] != s[DATA_W-1];
    if (r.ovf) begin
      r.val = s[DATA_W] ? S32_MIN : S32_MAX;
    end else begin
      r.val = s[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/lez_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lez_cfg_regs
// APB-style register file holding sigma, beta, rho and the time step.
// ----------------------------------------------------------------------------
module lez_cfg_regs #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output lez_pkg::cfg_t              cfg
);

  localparam logic [63:0] Q_ONE     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] SIGMA_RST = 64'd10 * Q_ONE;
  localparam logic [63:0] BETA_RST  = (64'd26666 * Q_ONE + 64'd5000) / 64'd10000;
  localparam logic [63:0] RHO_RST   = 64'd28 * Q_ONE;
  localparam logic [63:0] STEP_RST  = (Q_ONE + 64'd500) / 64'd1000;

  logic signed [31:0] sigma_r, sigma_nxt;
  logic signed [31:0] beta_r,  beta_nxt;
  logic signed [31:0] rho_r,   rho_nxt;
  logic [30:0]        step_r,  step_nxt;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    sigma_nxt = sigma_r;
    beta_nxt  = beta_r;
    rho_nxt   = rho_r;
    step_nxt  = step_r;
    if (wr_en) begin
      case (paddr[3:2])
        lez_pkg::REG_SIGMA: sigma_nxt = pwdata;
        lez_pkg::REG_BETA:  beta_nxt  = pwdata;
        lez_pkg::REG_RHO:   rho_nxt   = pwdata;
        lez_pkg::REG_STEP:  step_nxt  = pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RST[31:0];
      beta_r  <= BETA_RST[31:0];
      rho_r   <= RHO_RST[31:0];
      step_r  <= STEP_RST[30:0];
    end else begin
      sigma_r <= sigma_nxt;
      beta_r  <= beta_nxt;
      rho_r   <= rho_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      lez_pkg::REG_SIGMA: prdata = sigma_r;
      lez_pkg::REG_BETA:  prdata = beta_r;
      lez_pkg::REG_RHO:   prdata = rho_r;
      lez_pkg::REG_STEP:  prdata = {1'b0, step_r};
      default:            prdata = '0;
    endcase
  end

  assign cfg.sigma_gain = sigma_r;
  assign cfg.beta_gain  = beta_r;
  assign cfg.rho_gain   = rho_r;
  assign cfg.time_step  = step_r;

endmodule

>>> rtl/core/lez_qmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lez_qmul
// Shared fixed-point multiplier: registered product, then floor shift and
// saturation into a second register.
// ----------------------------------------------------------------------------
module lez_qmul #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                 clk,
  input  logic signed [31:0]   a,
  input  logic signed [31:0]   b,
  output lez_pkg::sat_res_t    q
);

  logic signed [63:0] prod_r, prod_nxt;
  logic signed [63:0] shifted;
  lez_pkg::sat_res_t  q_r, q_nxt;

  assign prod_nxt = a * b;
  // arithmetic shift gives floor rounding
  assign shifted  = prod_r >>> FRAC_BITS;

  always_comb begin
    q_nxt.ovf = shifted[63:31] != {33{shifted[31]}};
    if (q_nxt.ovf) begin
      q_nxt.val = shifted[63] ? lez_pkg::S32_MIN : lez_pkg::S32_MAX;
    end else begin
      q_nxt.val = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
  end

  assign q = q_r;

endmodule

>>> rtl/core/lorenz_euler_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_euler_step
// Lorenz attractor point generator, forward euler steps in signed fixed point
// with saturation, one shared multiplier and one saturating adder.
//
//   channel   handshake              word
//   in        in_valid / in_ready    in_restart
//   out       out_valid / out_ready  out_point_x/y/z, out_overflow
//   cfg       psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// An euler step runs through nine schedule states, S0 to S8, around the shared
// multiplier and one hand-off state before it reaches the result register; the
// next word is taken only when the sequencer is back in idle.
// A restart word skips the schedule and goes straight to the hand-off state.
// A result waits in its output register while the next word is worked on;
// a second finished result holds the sequencer until the first is taken.
// Reset is synchronous; the point returns to (1,1,1) and the gains to defaults.
// ----------------------------------------------------------------------------
module lorenz_euler_step #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic               out_overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8, ST_DONE
  } state_t;

  lez_pkg::cfg_t     cfg;
  lez_pkg::sat_res_t mq;
  lez_pkg::sat_res_t add_res;

  state_t             state_r, state_nxt;
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [31:0] ta_r, ta_nxt, tb_r, tb_nxt, tc_r, tc_nxt;
  logic signed [31:0] dy_r, dy_nxt, dz_r, dz_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic               pov_r, pov_nxt;

  logic signed [31:0] mul_a, mul_b, add_a, add_b;
  logic               add_sub;
  logic signed [31:0] dt_s;

  lez_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lez_qmul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_qmul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mq)
  );

  assign dt_s    = {1'b0, cfg.time_step};
  assign add_res = lez_pkg::sat_addsub(add_a, add_b, add_sub);

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    tc_nxt        = tc_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    pov_nxt       = pov_r;
    mul_a         = x_r;
    mul_b         = y_r;
    add_a         = y_r;
    add_b         = x_r;
    add_sub       = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ovf_nxt = 1'b0;
          if (in_restart) begin
            x_nxt     = Q_ONE;
            y_nxt     = Q_ONE;
            z_nxt     = Q_ONE;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_S0;
          end
        end
      end
      // y - x, issue x*y
      ST_S0: begin
        ta_nxt    = add_res.val;
        ovf_nxt   = ovf_r | add_res.ovf;
        state_nxt = ST_S1;
      end
      // rho - z, issue beta*z
      ST_S1: begin
        add_a     = cfg.rho_gain;
        add_b     = z_r;
        mul_a     = cfg.beta_gain;
        mul_b     = z_r;
        tb_nxt    = add_res.val;
        ovf_nxt   = ovf_r | add_res.ovf;
        state_nxt = ST_S2;
      end
      // keep x*y, issue sigma*(y-x)
      ST_S2: begin
        mul_a     = cfg.sigma_gain;
        mul_b     = ta_r;
        tc_nxt    = mq.val;
        ovf_nxt   = ovf_r | mq.ovf;
        state_nxt = ST_S3;
      end
      // dz = x*y - beta*z, issue x*(rho-z)
      ST_S3: begin
        mul_a     = x_r;
        mul_b     = tb_r;
        add_a     = tc_r;
        add_b     = mq.val;
        dz_nxt    = add_res.val;
        ovf_nxt   = ovf_r | mq.ovf | add_res.ovf;
        state_nxt = ST_S4;
      end
      // dx arrives, issue dt*dx
      ST_S4: begin
        mul_a     = dt_s;
        mul_b     = mq.val;
        ovf_nxt   = ovf_r | mq.ovf;
        state_nxt = ST_S5;
      end
      // dy = x*(rho-z) - y, issue dt*dz
      ST_S5: begin
        mul_a     = dt_s;
        mul_b     = dz_r;
        add_a     = mq.val;
        add_b     = y_r;
        dy_nxt    = add_res.val;
        ovf_nxt   = ovf_r | mq.ovf | add_res.ovf;
        state_nxt = ST_S6;
      end
      // x update, issue dt*dy
      ST_S6: begin
        mul_a     = dt_s;
        mul_b     = dy_r;
        add_a     = x_r;
        add_b     = mq.val;
        add_sub   = 1'b0;
        x_nxt     = add_res.val;
        ovf_nxt   = ovf_r | mq.ovf | add_res.ovf;
        state_nxt = ST_S7;
      end
      ST_S7: begin
        add_a     = z_r;
        add_b     = mq.val;
        add_sub   = 1'b0;
        z_nxt     = add_res.val;
        ovf_nxt   = ovf_r | mq.ovf | add_res.ovf;
        state_nxt = ST_S8;
      end
      ST_S8: begin
        add_a     = y_r;
        add_b     = mq.val;
        add_sub   = 1'b0;
        y_nxt     = add_res.val;
        ovf_nxt   = ovf_r | mq.ovf | add_res.ovf;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          px_nxt        = x_r;
          py_nxt        = y_r;
          pz_nxt        = z_r;
          pov_nxt       = ovf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      x_r         <= Q_ONE;
      y_r         <= Q_ONE;
      z_r         <= Q_ONE;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      z_r         <= z_nxt;
      ovf_r       <= ovf_nxt;
    end
    ta_r  <= ta_nxt;
    tb_r  <= tb_nxt;
    tc_r  <= tc_nxt;
    dy_r  <= dy_nxt;
    dz_r  <= dz_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pz_r  <= pz_nxt;
    pov_r <= pov_nxt;
  end

  assign in_ready     = state_r == ST_IDLE;
  assign out_valid    = out_valid_r;
  assign out_point_x  = px_r;
  assign out_point_y  = py_r;
  assign out_point_z  = pz_r;
  assign out_overflow = pov_r;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lorenz_euler_step. A scoreboard class keeps its own
// copy of the point and the gains, predicts each word the block should emit
// and checks the words that come out, field by field, in order. Gains are
// written over the register port between phases only while the block is idle.
// Phases cover defaults, extreme and random gains, with sender gaps and
// receiver stalls, and long receiver hold-offs that back up the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC = 20;
  localparam int LIMIT = 400000;
  localparam int PHASES = 9;
  localparam int RAND_WORDS = 76;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ovf;
  } point_t;

  class lorenz_scoreboard;
    longint sigma, beta, rho, dt;
    longint px, py, pz;
    bit     clipped;
    point_t points_due[$];
    int     errors;
    int     sat_seen;
    int     restarts;

    function new();
      sigma = 10485760;
      beta = 2796133;
      rho = 29360128;
      dt = 1049;
      px = longint'(1) << FRAC;
      py = px;
      pz = px;
      errors = 0;
      sat_seen = 0;
      restarts = 0;
    endfunction

    function void set_gain(logic [1:0] idx, logic [31:0] data);
      case (idx)
        lez_pkg::REG_SIGMA: sigma = longint'($signed(data));
        lez_pkg::REG_BETA:  beta = longint'($signed(data));
        lez_pkg::REG_RHO:   rho = longint'($signed(data));
        lez_pkg::REG_STEP:  dt = longint'({1'b0, data[30:0]});
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) begin
        clipped = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clipped = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clip(p >>> FRAC);
    endfunction

    // one euler step from the old point, all derivatives from old x, y, z
    function void advance_point();
      longint dx, dy, dz, t;
      clipped = 1'b0;
      t = clip(py - px);
      dx = qmul(sigma, t);
      t = clip(rho - pz);
      t = qmul(px, t);
      dy = clip(t - py);
      t = qmul(px, py);
      dz = clip(t - qmul(beta, pz));
      px = clip(px + qmul(dt, dx));
      py = clip(py + qmul(dt, dy));
      pz = clip(pz + qmul(dt, dz));
    endfunction

    function void note_word(bit restart);
      point_t e;
      if (restart) begin
        px = longint'(1) << FRAC;
        py = px;
        pz = px;
        e.ovf = 1'b0;
        restarts++;
      end else begin
        advance_point();
        e.ovf = clipped;
      end
      e.x = px[31:0];
      e.y = py[31:0];
      e.z = pz[31:0];
      points_due.push_back(e);
    endfunction

    function void check_word(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic ovf);
      point_t e;
      if (points_due.size() == 0) begin
        $error("result word with none expected");
        errors++;
        return;
      end
      e = points_due.pop_front();
      if (ovf === 1'b1) sat_seen++;
      if (x !== e.x) begin
        $error("point_x expected %0d actual %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("point_y expected %0d actual %0d", e.y, y);
        errors++;
      end
      if (z !== e.z) begin
        $error("point_z expected %0d actual %0d", e.z, z);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflow expected %0d actual %0d", e.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return points_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_point_x;
  logic signed [31:0] out_point_y;
  logic signed [31:0] out_point_z;
  logic               out_overflow;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  lorenz_scoreboard sb;
  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_req = 0;
  int hold_left = 0;
  int cycles = 0;
  int words_sent = 0;

  lorenz_euler_step #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_point_z(out_point_z), .out_overflow(out_overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("lorenz_euler_step: mismatch");
      $finish;
    end
  end

  // result side: check, then choose ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_point_x, out_point_y, out_point_z, out_overflow);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  task automatic send_word(input bit restart);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_word(restart);
    words_sent++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_gain(idx, data);
  endtask

  task automatic set_gains(input logic [31:0] s, input logic [31:0] b,
                           input logic [31:0] r, input logic [31:0] t);
    reg_write(lez_pkg::REG_SIGMA, s);
    reg_write(lez_pkg::REG_BETA, b);
    reg_write(lez_pkg::REG_RHO, r);
    reg_write(lez_pkg::REG_STEP, t);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int mode;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults from reset: restart, a run of steps, restart again
    send_word(1'b1);
    repeat (10) send_word(1'b0);
    send_word(1'b1);
    repeat (4) send_word(1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      mode = p % 4;
      case (p)
        0: set_gains(32'd10485760, 32'd2796133, 32'd29360128, 32'd1049);
        1: set_gains(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        2: set_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        3: set_gains(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        4: set_gains(32'd0, 32'd0, 32'd0, 32'd0);
        5: set_gains($urandom, $urandom, $urandom, $urandom);
        8: set_gains(32'd10485760, 32'd2796133, 32'd29360128,
                     32'h8000_0000 | $urandom_range(1 << 16));
        default: set_gains($urandom_range(40 << FRAC) - (8 << FRAC),
                           $urandom_range(8 << FRAC),
                           $urandom_range(60 << FRAC) - (10 << FRAC),
                           $urandom_range(1 << 16));
      endcase
      snd_idle = (mode == 1) ? 88 : (mode == 3) ? 30 : 0;
      rcv_stall = (mode == 2) ? 88 : (mode == 3) ? 30 : 0;
      if (p >= 1 && p <= 4) begin
        // fresh point, then steps; extreme gains saturate and step on from the clip
        send_word(1'b1);
        repeat (3) send_word(1'b0);
      end
      if (mode == 0)
        hold_req = 300;
      send_word(1'b1);
      for (int i = 0; i < RAND_WORDS; i++)
        send_word($urandom_range(11) == 0);
    end

    drain();
    $display("sent %0d words over %0d gain settings, %0d of them restarts",
             words_sent, PHASES + 1, sb.restarts);
    $display("%0d result words flagged saturation, %0d field errors",
             sb.sat_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("lorenz_euler_step: match");
    end else begin
      $display("lorenz_euler_step: mismatch");
    end
    $finish;
  end

endmodule
